// ===== rtl/i2crm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C register master package
// Shared types, state codes and constants for the I2C register master.
// ----------------------------------------------------------------------------
package i2crm_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_BYTE  = 2'd3
  } action_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHK_HI, ST_CHK_LO, ST_TX_LO, ST_TX_HI, ST_ACK_LO, ST_ACK_HI,
    ST_ACK_WAIT, ST_WANT, ST_RS_HI, ST_RS_FALL, ST_RS_GO, ST_RX_HI, ST_RX_LO,
    ST_MACK_SET, ST_MACK_HI, ST_MACK_END, ST_SP_HI, ST_SP_END
  } seq_state_e;

  typedef enum logic [1:0] {
    KIND_ADDR, KIND_REG, KIND_DATA, KIND_RADDR
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BUSY    = 2'd1,
    STAT_NO_ACK  = 2'd2,
    STAT_UNUSED  = 2'd3
  } status_e;

  localparam logic [7:0] AckWaitReset = 8'd21;
  localparam int         QDepth       = 2;
  // APB byte address of the acknowledge wait limit register
  localparam logic [1:0] RegAckLimit  = 2'd0;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] wr_data;
    logic       sda_level;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_drive;
    logic       busy_res;
    logic       want_byte;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       last_byte;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

  // classified request from front to back
  typedef struct packed {
    logic       is_cmd;
    logic       is_read;
    logic       is_byte;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] count;
    logic [7:0] wr_data;
    logic       sda;
  } req_t;

endpackage

// ===== rtl/i2c_register_master_top.sv =====
// ----------------------------------------------------------------------------
// I2C register master top level
// Request queue, bus engine and APB configuration register.
// ----------------------------------------------------------------------------
// A result is written into the output queue at the clock edge that accepts its request.
// Throughput: one request per cycle while the output queue is not full.
// Reset: asynchronous, active low; bus released, ack_wait_limit back to 21,
// both queues emptied.
module i2c_register_master_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  i2crm_pkg::in_item_t  in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output i2crm_pkg::out_item_t out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import i2crm_pkg::*;

  logic [7:0] limit_q;
  logic       rv, take;
  req_t       rq;

  assign pready = 1'b1;
  assign prdata = (paddr == RegAckLimit) ? {24'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= AckWaitReset;
    end else if (psel && penable && pwrite && paddr == RegAckLimit) begin
      limit_q <= pwdata[7:0];
    end
  end

  i2crm_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .in_i(in_item_i),
    .req_valid_o(rv), .req_o(rq), .req_take_i(take)
  );

  i2crm_engine u_engine (
    .clk_i, .rst_ni, .ack_limit_i(limit_q), .req_valid_i(rv), .req_i(rq),
    .req_take_o(take), .empty_o(empty), .pop_i(pop), .out_o(out_item_o)
  );

endmodule

// ===== rtl/i2crm_front.sv =====
// ----------------------------------------------------------------------------
// I2C register master front end
// Accepts input requests, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module i2crm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  i2crm_pkg::in_item_t in_i,
  output logic               req_valid_o,
  output i2crm_pkg::req_t    req_o,
  input  logic               req_take_i
);
  import i2crm_pkg::*;

  localparam int PW = $clog2(QDepth);

  req_t           mem_q [QDepth];
  logic [PW-1:0]  wp_q, rp_q;
  logic [PW:0]    cnt_q;
  req_t           cls;
  logic           wr, rd;

  always_comb begin
    cls          = '0;
    cls.is_cmd   = (in_i.action == ACT_WRITE) || (in_i.action == ACT_READ);
    cls.is_read  = (in_i.action == ACT_READ);
    cls.is_byte  = (in_i.action == ACT_BYTE);
    cls.dev_addr = in_i.dev_addr;
    cls.reg_addr = in_i.reg_addr;
    // zero count behaves as one
    cls.count    = (in_i.byte_count == 8'd0) ? 8'd1 : in_i.byte_count;
    cls.wr_data  = in_i.wr_data;
    cls.sda      = in_i.sda_level;
  end

  assign full_o      = (cnt_q == (PW+1)'(QDepth));
  assign wr          = push_i && !full_o;
  assign req_valid_o = (cnt_q != '0);
  assign rd          = req_take_i && req_valid_o;
  assign req_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

endmodule

// ===== rtl/i2crm_engine.sv =====
// ----------------------------------------------------------------------------
// I2C register master engine
// Bus sequencer: one half-bit phase per request, result into an output queue.
// ----------------------------------------------------------------------------
module i2crm_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          ack_limit_i,
  input  logic                req_valid_i,
  input  i2crm_pkg::req_t     req_i,
  output logic                req_take_o,
  output logic                empty_o,
  input  logic                pop_i,
  output i2crm_pkg::out_item_t out_o
);
  import i2crm_pkg::*;

  localparam int PW = $clog2(QDepth);

  seq_state_e  st_q, st_d;
  logic [3:0]  bc_q, bc_d;
  logic [7:0]  sh_q, sh_d, bl_q, bl_d, aw_q, aw_d, sreg_q, sreg_d;
  logic [6:0]  sdev_q, sdev_d;
  logic        rd_q, rd_d, c_q, c_d, d_q, d_d;
  kind_e       kind_q, kind_d;
  status_e     es_q, es_d;
  out_item_t   res;

  out_item_t   oq_q [QDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          go, opop;
  logic [7:0]    shn;

  assign req_take_o = req_valid_i && (cnt_q != (PW+1)'(QDepth));
  assign go         = req_take_o;
  assign empty_o    = (cnt_q == '0);
  assign opop       = pop_i && !empty_o;
  assign out_o      = oq_q[rp_q];

  always_comb begin
    st_d = st_q; bc_d = bc_q; sh_d = sh_q; bl_d = bl_q; aw_d = aw_q;
    sreg_d = sreg_q; sdev_d = sdev_q; rd_d = rd_q; kind_d = kind_q; es_d = es_q;
    c_d = c_q; d_d = d_q;
    res = '0;
    shn = '0;
    if (req_i.is_cmd) begin
      if (st_q == ST_IDLE) begin
        sdev_d = req_i.dev_addr; sreg_d = req_i.reg_addr; bl_d = req_i.count;
        rd_d = req_i.is_read; es_d = STAT_OK; c_d = 1'b1; d_d = 1'b1;
        st_d = ST_CHK_HI;
      end
    end else if (req_i.is_byte) begin
      if (st_q == ST_WANT) begin
        sh_d = req_i.wr_data; bc_d = '0; kind_d = KIND_DATA;
        c_d = 1'b0; d_d = req_i.wr_data[7]; st_d = ST_TX_HI;
      end
    end else begin
      unique case (st_q)
        ST_IDLE: begin c_d = 1'b1; d_d = 1'b1; end
        ST_CHK_HI, ST_CHK_LO: begin
          if (req_i.sda != (st_q == ST_CHK_HI)) begin
            c_d = 1'b1; d_d = 1'b1; res.done_res = 1'b1; res.status = STAT_BUSY;
            st_d = ST_IDLE;
          end else if (st_q == ST_CHK_HI) begin
            c_d = 1'b1; d_d = 1'b0; st_d = ST_CHK_LO;
          end else begin
            sh_d = {sdev_q, 1'b0}; bc_d = '0; kind_d = KIND_ADDR;
            c_d = 1'b0; d_d = sdev_q[6]; st_d = ST_TX_HI;
          end
        end
        ST_TX_LO: begin c_d = 1'b0; d_d = sh_q[7]; st_d = ST_TX_HI; end
        ST_TX_HI: begin
          c_d = 1'b1; d_d = sh_q[7]; sh_d = {sh_q[6:0], 1'b0}; bc_d = bc_q + 4'd1;
          st_d = (bc_d >= 4'd8) ? ST_ACK_LO : ST_TX_LO;
        end
        ST_ACK_LO: begin c_d = 1'b0; d_d = 1'b1; st_d = ST_ACK_HI; end
        ST_ACK_HI: begin c_d = 1'b1; d_d = 1'b1; aw_d = '0; st_d = ST_ACK_WAIT; end
        ST_ACK_WAIT: begin
          if (req_i.sda && aw_q < ack_limit_i) begin
            aw_d = aw_q + 8'd1; c_d = 1'b1; d_d = 1'b1;
          end else begin
            case (kind_q)
              KIND_ADDR: begin
                if (req_i.sda) begin
                  es_d = STAT_NO_ACK; c_d = 1'b0; d_d = 1'b0; st_d = ST_SP_HI;
                end else begin
                  sh_d = sreg_q; bc_d = '0; kind_d = KIND_REG;
                  c_d = 1'b0; d_d = sreg_q[7]; st_d = ST_TX_HI;
                end
              end
              KIND_REG: begin
                c_d = 1'b0; d_d = 1'b1; st_d = rd_q ? ST_RS_HI : ST_WANT;
              end
              KIND_DATA: begin
                if (req_i.sda) begin
                  es_d = STAT_NO_ACK; c_d = 1'b0; d_d = 1'b0; st_d = ST_SP_HI;
                end else begin
                  bl_d = bl_q - 8'd1;
                  if (bl_d == 8'd0) begin
                    es_d = STAT_OK; c_d = 1'b0; d_d = 1'b0; st_d = ST_SP_HI;
                  end else begin
                    c_d = 1'b0; d_d = 1'b1; st_d = ST_WANT;
                  end
                end
              end
              default: begin
                c_d = 1'b0; d_d = 1'b1; sh_d = '0; bc_d = '0; st_d = ST_RX_HI;
              end
            endcase
          end
        end
        ST_WANT: begin c_d = 1'b0; d_d = 1'b1; end
        ST_RS_HI: begin c_d = 1'b1; d_d = 1'b1; st_d = ST_RS_FALL; end
        ST_RS_FALL: begin c_d = 1'b1; d_d = 1'b0; st_d = ST_RS_GO; end
        ST_RS_GO: begin
          sh_d = {sdev_q, 1'b1}; bc_d = '0; kind_d = KIND_RADDR;
          c_d = 1'b0; d_d = sdev_q[6]; st_d = ST_TX_HI;
        end
        ST_RX_HI: begin c_d = 1'b1; d_d = 1'b1; st_d = ST_RX_LO; end
        ST_RX_LO: begin
          shn = {sh_q[6:0], req_i.sda}; sh_d = shn; bc_d = bc_q + 4'd1;
          c_d = 1'b0; d_d = 1'b1;
          if (bc_d >= 4'd8) begin
            res.byte_valid = 1'b1; res.read_byte = shn;
            res.last_byte = (bl_q <= 8'd1); st_d = ST_MACK_SET;
          end else begin
            st_d = ST_RX_HI;
          end
        end
        ST_MACK_SET: begin c_d = 1'b0; d_d = (bl_q <= 8'd1); st_d = ST_MACK_HI; end
        ST_MACK_HI: begin c_d = 1'b1; d_d = (bl_q <= 8'd1); st_d = ST_MACK_END; end
        ST_MACK_END: begin
          bl_d = (bl_q != 8'd0) ? bl_q - 8'd1 : 8'd0;
          if (bl_d == 8'd0) begin
            es_d = STAT_OK; c_d = 1'b0; d_d = 1'b0; st_d = ST_SP_HI;
          end else begin
            c_d = 1'b0; d_d = 1'b1; sh_d = '0; bc_d = '0; st_d = ST_RX_HI;
          end
        end
        ST_SP_HI: begin c_d = 1'b1; d_d = 1'b0; st_d = ST_SP_END; end
        ST_SP_END: begin
          c_d = 1'b1; d_d = 1'b1; res.done_res = 1'b1; res.status = es_q;
          st_d = ST_IDLE;
        end
        default: begin c_d = 1'b1; d_d = 1'b1; st_d = ST_IDLE; end
      endcase
    end
    res.scl       = c_d;
    res.sda_drive = d_d;
    res.busy_res  = (st_d != ST_IDLE);
    res.want_byte = (st_d == ST_WANT);
  end

  always_ff @(posedge clk_i) begin
    if (go) oq_q[wp_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; bc_q <= '0; sh_q <= '0; bl_q <= '0; aw_q <= '0;
      sreg_q <= '0; sdev_q <= '0; rd_q <= 1'b0; kind_q <= KIND_ADDR;
      es_q <= STAT_OK; c_q <= 1'b1; d_q <= 1'b1;
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (go) begin
        st_q <= st_d; bc_q <= bc_d; sh_q <= sh_d; bl_q <= bl_d; aw_q <= aw_d;
        sreg_q <= sreg_d; sdev_q <= sdev_d; rd_q <= rd_d; kind_q <= kind_d;
        es_q <= es_d; c_q <= c_d; d_q <= d_d;
        wp_q <= wp_q + 1'b1;
      end
      if (opop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(go) - (PW+1)'(opop);
    end
  end

endmodule

// ===== rtl/i2crm_checker.sv =====
// ----------------------------------------------------------------------------
// I2C register master checker
// Port-level properties of the I2C register master.
// ----------------------------------------------------------------------------
module i2crm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 empty,
  input logic                 pop,
  input i2crm_pkg::out_item_t out_item_o
);
  import i2crm_pkg::*;

  a_stat_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.done_res) |-> out_item_o.status == STAT_OK)
    else $error("status without done");

  a_want_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.want_byte) |-> out_item_o.busy_res)
    else $error("want without busy");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.byte_valid) |-> out_item_o.read_byte == 8'd0)
    else $error("stray read byte");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("result changed while stalled");

endmodule

bind i2c_register_master_top i2crm_checker u_checker (
  .clk_i, .rst_ni, .empty, .pop, .out_item_o
);
